FILE: hw/rtl/lie_pkg.sv
`default_nettype none

package lie_pkg;

  // store geometry
  localparam int MAX_LINES   = 64;
  localparam int MAX_COLS    = 64;
  localparam int PIVOT_DEPTH = 512;
  localparam int ELEM_BITS   = 64;

  localparam int LINE_W  = $clog2(MAX_LINES);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int MADDR_W = $clog2(MAX_LINES * MAX_COLS);
  localparam int PADDR_W = $clog2(PIVOT_DEPTH);

  // field widths fixed by the interface
  localparam int KIND_W  = 2;
  localparam int LNUM_W  = 6;
  localparam int CNUM_W  = 6;
  localparam int VAL_W   = 64;
  localparam int PPOS_W  = 9;
  localparam int PLINE_W = 7;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 7;
  localparam int STEP_W  = 5;

  // run walk: signed one-based index and signed pivot slot
  localparam int IDX_W  = 9;
  localparam int SLOT_W = (PADDR_W + 2 > 13) ? PADDR_W + 2 : 13;

  localparam logic signed [IDX_W-1:0]  IDX_ONE    = IDX_W'(1);
  localparam logic signed [IDX_W-1:0]  IDX_MAX    = IDX_W'(MAX_LINES);
  localparam logic signed [SLOT_W-1:0] SLOT_ONE   = SLOT_W'(1);
  localparam logic signed [SLOT_W-1:0] SLOT_DEPTH = SLOT_W'(PIVOT_DEPTH);

  // command queue between front and back
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

  // register port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [CNT_W-1:0]  COL_COUNT_RST  = 7'd64;
  localparam logic [CNT_W-1:0]  FIRST_IDX_RST  = 7'd1;
  localparam logic [CNT_W-1:0]  LAST_IDX_RST   = 7'd1;
  localparam logic [STEP_W-1:0] PIVOT_STEP_RST = 5'd1;

  typedef enum logic [1:0] {
    REG_COL_COUNT   = 2'd0,
    REG_FIRST_INDEX = 2'd1,
    REG_LAST_INDEX  = 2'd2,
    REG_PIVOT_STEP  = 2'd3
  } reg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    OP_WRITE = 2'd0,
    OP_PIVOT = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_ACCEPTED = 2'd0,
    STAT_CLEAN    = 2'd1,
    STAT_SKIPPED  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CNT_W-1:0]         col_count;
    logic [CNT_W-1:0]         first_index;
    logic [CNT_W-1:0]         last_index;
    logic signed [STEP_W-1:0] pivot_step;
  } cfg_t;

  typedef struct packed {
    op_e                  op;
    logic                 addr_ok;
    logic [MADDR_W-1:0]   maddr;
    logic [ELEM_BITS-1:0] value;
    logic                 pos_ok;
    logic [PADDR_W-1:0]   ppos;
    logic [PLINE_W-1:0]   pline;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lie_ram.sv
`default_nettype none

module lie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lie_front.sv
`default_nettype none

module lie_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [lie_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [lie_pkg::LNUM_W-1:0]    line_number_i,
  input  wire logic [lie_pkg::CNUM_W-1:0]    column_number_i,
  input  wire logic [lie_pkg::VAL_W-1:0]     element_value_i,
  input  wire logic [lie_pkg::PPOS_W-1:0]    pivot_position_i,
  input  wire logic [lie_pkg::PLINE_W-1:0]   pivot_line_i,
  output logic                               cmd_valid_o,
  input  wire logic                          cmd_ready_i,
  output lie_pkg::cmd_t                      cmd_o
);

  import lie_pkg::*;

  cmd_t                cmd_in;
  cmd_t                fifo_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FQ_PTR_W:0]   count_q, count_d;
  logic                wr_en, rd_en;

  // decode and range-check the incoming item
  always_comb begin
    cmd_in.op      = op_e'(kind_i);
    cmd_in.addr_ok = (32'(line_number_i) < MAX_LINES) && (32'(column_number_i) < MAX_COLS);
    cmd_in.maddr   = MADDR_W'(line_number_i) * MADDR_W'(MAX_COLS) + MADDR_W'(column_number_i);
    cmd_in.value   = element_value_i[ELEM_BITS-1:0];
    cmd_in.pos_ok  = 32'(pivot_position_i) < PIVOT_DEPTH;
    cmd_in.ppos    = PADDR_W'(pivot_position_i);
    cmd_in.pline   = pivot_line_i;
  end

  // queue control
  assign full        = count_q == (FQ_PTR_W + 1)'(FQ_DEPTH);
  assign cmd_valid_o = count_q != '0;
  assign wr_en       = push && !full;
  assign rd_en       = cmd_ready_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + FQ_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + FQ_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + (FQ_PTR_W + 1)'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - (FQ_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lie_back.sv
`default_nettype none

module lie_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lie_pkg::cfg_t               cfg_i,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_ready_o,
  input  wire lie_pkg::cmd_t               cmd_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [lie_pkg::VAL_W-1:0]        read_value_o,
  output logic [lie_pkg::STAT_W-1:0]       status_o
);

  import lie_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_RDWAIT = 8'b0000_0010,
    ST_PIV    = 8'b0000_0100,
    ST_PWAIT  = 8'b0000_1000,
    ST_RA     = 8'b0001_0000,
    ST_RB     = 8'b0010_0000,
    ST_WA     = 8'b0100_0000,
    ST_WB     = 8'b1000_0000
  } state_e;

  state_e                   state_q, state_d;
  logic signed [IDX_W-1:0]  i_q, i_d, stop_q, stop_d;
  logic signed [SLOT_W-1:0] slot_q, slot_d;
  logic                     dir_neg_q, dir_neg_d;
  logic                     skip_q, skip_d;
  logic [LINE_W-1:0]        line_a_q, line_a_d, line_b_q, line_b_d;
  logic [COL_W-1:0]         col_q, col_d;
  logic [ELEM_BITS-1:0]     tmp_q, tmp_d;
  logic                     rd_ok_q, rd_ok_d;

  logic                     res_valid_q, res_valid_d;
  logic [VAL_W-1:0]         res_rd_q, res_rd_d;
  status_e                  res_status_q, res_status_d;

  // memory ports
  logic                     m_we, m_re;
  logic [MADDR_W-1:0]       m_waddr, m_raddr, m_addr_a, m_addr_b;
  logic [ELEM_BITS-1:0]     m_wdata, m_rdata;
  logic                     p_we, p_re;
  logic [PADDR_W-1:0]       p_waddr, p_raddr;
  logic [PLINE_W-1:0]       p_wdata, p_rdata;

  // run setup and walk helpers
  logic                     step_neg, step_zero;
  logic signed [7:0]        one_m_last;
  logic signed [SLOT_W-1:0] slot_neg, slot_pos, slot_init, slot_adv, step_ext;
  logic signed [IDX_W-1:0]  i_init, stop_init, i_adv, p_s;
  logic                     more_init, more_adv, slot_ok, p_bad, i_bad;
  logic [CNT_W-1:0]         ncols;
  logic                     col_last, out_free, prod, adv;
  logic [VAL_W-1:0]         prod_rd;
  status_e                  prod_status;

  lie_ram #(
    .WIDTH(ELEM_BITS),
    .DEPTH(MAX_LINES * MAX_COLS)
  ) u_matrix (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .re_i   (m_re),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  lie_ram #(
    .WIDTH(PLINE_W),
    .DEPTH(PIVOT_DEPTH)
  ) u_pivots (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  // start point of a run
  assign step_neg   = cfg_i.pivot_step[STEP_W-1];
  assign step_zero  = cfg_i.pivot_step == '0;
  assign step_ext   = SLOT_W'($signed(cfg_i.pivot_step));
  assign one_m_last = 8'sd1 - $signed({1'b0, cfg_i.last_index});
  assign slot_neg   = one_m_last * $signed(cfg_i.pivot_step);
  assign slot_pos   = $signed({{(SLOT_W - CNT_W){1'b0}}, cfg_i.first_index}) - SLOT_ONE;
  assign slot_init  = step_neg ? slot_neg : slot_pos;
  assign i_init     = step_neg ? $signed({{(IDX_W - CNT_W){1'b0}}, cfg_i.last_index})
                               : $signed({{(IDX_W - CNT_W){1'b0}}, cfg_i.first_index});
  assign stop_init  = step_neg ? $signed({{(IDX_W - CNT_W){1'b0}}, cfg_i.first_index})
                               : $signed({{(IDX_W - CNT_W){1'b0}}, cfg_i.last_index});
  assign more_init  = step_neg ? (i_init >= stop_init) : (i_init <= stop_init);

  // next interchange index and slot
  assign i_adv    = dir_neg_q ? i_q - IDX_ONE : i_q + IDX_ONE;
  assign slot_adv = slot_q + step_ext;
  assign more_adv = dir_neg_q ? (i_adv >= stop_q) : (i_adv <= stop_q);

  // range checks on slot, pivot line and index line
  assign slot_ok = !slot_q[SLOT_W-1] && (slot_q < SLOT_DEPTH);
  assign p_s     = $signed({{(IDX_W - PLINE_W){1'b0}}, p_rdata});
  assign p_bad   = (p_s < IDX_ONE) || (p_s > IDX_MAX);
  assign i_bad   = (i_q < IDX_ONE) || (i_q > IDX_MAX);

  // column count saturates at the line length
  assign ncols    = (32'(cfg_i.col_count) > MAX_COLS) ? CNT_W'(MAX_COLS) : cfg_i.col_count;
  assign col_last = (CNT_W'(col_q) + CNT_W'(1)) == ncols;

  assign m_addr_a = MADDR_W'(line_a_q) * MADDR_W'(MAX_COLS) + MADDR_W'(col_q);
  assign m_addr_b = MADDR_W'(line_b_q) * MADDR_W'(MAX_COLS) + MADDR_W'(col_q);

  assign out_free = !res_valid_q || pop;

  // sequencer
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    stop_d      = stop_q;
    slot_d      = slot_q;
    dir_neg_d   = dir_neg_q;
    skip_d      = skip_q;
    line_a_d    = line_a_q;
    line_b_d    = line_b_q;
    col_d       = col_q;
    tmp_d       = tmp_q;
    rd_ok_d     = rd_ok_q;
    cmd_ready_o = 1'b0;
    m_we        = 1'b0;
    m_waddr     = m_addr_a;
    m_wdata     = tmp_q;
    m_re        = 1'b0;
    m_raddr     = m_addr_a;
    p_we        = 1'b0;
    p_waddr     = cmd_i.ppos;
    p_wdata     = cmd_i.pline;
    p_re        = 1'b0;
    p_raddr     = slot_q[PADDR_W-1:0];
    prod        = 1'b0;
    prod_rd     = '0;
    prod_status = STAT_ACCEPTED;
    adv         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.op)
            OP_WRITE: begin
              m_we    = cmd_i.addr_ok;
              m_waddr = cmd_i.maddr;
              m_wdata = cmd_i.value;
              prod    = 1'b1;
            end
            OP_PIVOT: begin
              p_we = cmd_i.pos_ok;
              prod = 1'b1;
            end
            OP_READ: begin
              m_re    = cmd_i.addr_ok;
              m_raddr = cmd_i.maddr;
              rd_ok_d = cmd_i.addr_ok;
              state_d = ST_RDWAIT;
            end
            OP_RUN: begin
              i_d       = i_init;
              stop_d    = stop_init;
              slot_d    = slot_init;
              dir_neg_d = step_neg;
              skip_d    = 1'b0;
              if (step_zero || !more_init) begin
                prod        = 1'b1;
                prod_status = STAT_CLEAN;
              end else begin
                state_d = ST_PIV;
              end
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        prod    = 1'b1;
        prod_rd = rd_ok_q ? VAL_W'(m_rdata) : '0;
        state_d = ST_IDLE;
      end
      ST_PIV: begin
        if (!slot_ok) begin
          skip_d = 1'b1;
          adv    = 1'b1;
        end else begin
          p_re    = 1'b1;
          state_d = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (p_s == i_q) begin
          adv = 1'b1;
        end else if (p_bad || i_bad) begin
          skip_d = 1'b1;
          adv    = 1'b1;
        end else if (ncols == '0) begin
          adv = 1'b1;
        end else begin
          line_a_d = LINE_W'(i_q - IDX_ONE);
          line_b_d = LINE_W'(p_s - IDX_ONE);
          col_d    = '0;
          state_d  = ST_RA;
        end
      end
      ST_RA: begin
        m_re    = 1'b1;
        m_raddr = m_addr_a;
        state_d = ST_RB;
      end
      ST_RB: begin
        tmp_d   = m_rdata;
        m_re    = 1'b1;
        m_raddr = m_addr_b;
        state_d = ST_WA;
      end
      ST_WA: begin
        m_we    = 1'b1;
        m_waddr = m_addr_a;
        m_wdata = m_rdata;
        state_d = ST_WB;
      end
      ST_WB: begin
        m_we    = 1'b1;
        m_waddr = m_addr_b;
        m_wdata = tmp_q;
        if (col_last) begin
          adv = 1'b1;
        end else begin
          col_d   = col_q + COL_W'(1);
          state_d = ST_RA;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // step to the next interchange or finish the run
    if (adv) begin
      i_d    = i_adv;
      slot_d = slot_adv;
      if (more_adv) begin
        state_d = ST_PIV;
      end else begin
        state_d     = ST_IDLE;
        prod        = 1'b1;
        prod_status = skip_d ? STAT_SKIPPED : STAT_CLEAN;
      end
    end
  end

  // result register
  always_comb begin
    res_valid_d  = res_valid_q && !pop;
    res_rd_d     = res_rd_q;
    res_status_d = res_status_q;
    if (prod) begin
      res_valid_d  = 1'b1;
      res_rd_d     = prod_rd;
      res_status_d = prod_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    stop_q       <= stop_d;
    slot_q       <= slot_d;
    dir_neg_q    <= dir_neg_d;
    skip_q       <= skip_d;
    line_a_q     <= line_a_d;
    line_b_q     <= line_b_d;
    col_q        <= col_d;
    tmp_q        <= tmp_d;
    rd_ok_q      <= rd_ok_d;
    res_rd_q     <= res_rd_d;
    res_status_q <= res_status_d;
  end

  assign empty        = !res_valid_q;
  assign read_value_o = res_rd_q;
  assign status_o     = res_status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/line_interchange_engine.sv
// path: writes and pivot writes pass the queue and result register, reads also read-wait;
//   a run: per index pivot read, then wait if in range; per column read A, B, write A, B
// throughput: one write per cycle while results are free or popped; a read holds off new
//   items until its result is ready; a 4-entry queue decouples input
// reset: queue and result register empty, config registers at their reset values, stores
//   hold no defined contents and need no clearing pass
`default_nettype none

module line_interchange_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lie_pkg::APB_AW-1:0]    paddr,
  input  wire logic [lie_pkg::APB_DW-1:0]    pwdata,
  output logic      [lie_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  // item side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [lie_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [lie_pkg::LNUM_W-1:0]    line_number_i,
  input  wire logic [lie_pkg::CNUM_W-1:0]    column_number_i,
  input  wire logic [lie_pkg::VAL_W-1:0]     element_value_i,
  input  wire logic [lie_pkg::PPOS_W-1:0]    pivot_position_i,
  input  wire logic [lie_pkg::PLINE_W-1:0]   pivot_line_i,
  // result side
  output logic                               empty,
  input  wire logic                          pop,
  output logic      [lie_pkg::VAL_W-1:0]     read_value_o,
  output logic      [lie_pkg::STAT_W-1:0]    status_o
);

  import lie_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     cfg_we;
  logic     cmd_valid, cmd_ready;
  cmd_t     cmd;

  // register writes
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (reg_idx)
        REG_COL_COUNT:   cfg_d.col_count   = pwdata[CNT_W-1:0];
        REG_FIRST_INDEX: cfg_d.first_index = pwdata[CNT_W-1:0];
        REG_LAST_INDEX:  cfg_d.last_index  = pwdata[CNT_W-1:0];
        REG_PIVOT_STEP:  cfg_d.pivot_step  = $signed(pwdata[STEP_W-1:0]);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col_count   <= COL_COUNT_RST;
      cfg_q.first_index <= FIRST_IDX_RST;
      cfg_q.last_index  <= LAST_IDX_RST;
      cfg_q.pivot_step  <= $signed(PIVOT_STEP_RST);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_COL_COUNT:   prdata = {{(APB_DW - CNT_W){1'b0}}, cfg_q.col_count};
      REG_FIRST_INDEX: prdata = {{(APB_DW - CNT_W){1'b0}}, cfg_q.first_index};
      REG_LAST_INDEX:  prdata = {{(APB_DW - CNT_W){1'b0}}, cfg_q.last_index};
      REG_PIVOT_STEP:  prdata = {{(APB_DW - STEP_W){1'b0}}, cfg_q.pivot_step};
    endcase
  end

  // front end: decode and queue items
  lie_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .kind_i          (kind_i),
    .line_number_i   (line_number_i),
    .column_number_i (column_number_i),
    .element_value_i (element_value_i),
    .pivot_position_i(pivot_position_i),
    .pivot_line_i    (pivot_line_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  // back end: stores, interchange sequencer and result register
  lie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .read_value_o(read_value_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire
